// ===== rtl/rps_pkg.sv =====
// Shared types and constants of the RPL parent selection block.
package rps_pkg;

	localparam int WORD_W              = 16;
	localparam int CFG_IDX_W           = 2;
	localparam int PIDX_W              = 3;
	localparam int MAX_NEIGHBORS_DEF   = 8;
	localparam int PARENT_SET_SIZE_DEF = 4;

	localparam logic [WORD_W-1:0] SAT_WORD         = {WORD_W{1'b1}};
	localparam logic [WORD_W-1:0] MIN_HOP_RESET    = WORD_W'(256);
	localparam logic [WORD_W-1:0] MAX_INC_RESET    = '0;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_HOP_RANK_INCREASE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANK_INCREASE     = CFG_IDX_W'(1);

	typedef struct packed {
		logic [WORD_W-1:0] neighbor_rank;
		logic [WORD_W-1:0] link_cost;
		logic              last_neighbor;
	} nbr_t;

	typedef struct packed {
		logic [PIDX_W-1:0] parent_index;
		logic [WORD_W-1:0] parent_path_cost;
		logic              is_preferred;
		logic [WORD_W-1:0] own_rank;
		logic              last_parent;
	} par_t;

	typedef struct packed {
		logic [WORD_W-1:0] rank;
		logic [WORD_W-1:0] cost;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_UPDATE,
		ST_APPLY,
		ST_LOAD,
		ST_SEND
	} state_t;

endpackage

// ===== rtl/rps_store.sv =====
// Neighbor table: one synchronous memory of rank and link cost pairs.
module rps_store #(
	parameter int DEPTH = rps_pkg::MAX_NEIGHBORS_DEF,
	parameter int AW    = 3
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  rps_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output rps_pkg::entry_t rdata
);

	rps_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rps_div.sv =====
// Restoring divider that returns the remainder, one quotient bit per cycle.
module rps_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rps_pkg::WORD_W-1:0] dividend,
	input  logic [rps_pkg::WORD_W-1:0] divisor,
	output logic                       done,
	output logic [rps_pkg::WORD_W-1:0] remainder
);

	localparam int W     = rps_pkg::WORD_W;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     sh_q;
	logic [W-1:0]     div_q;
	logic [W:0]       trial;
	logic [W:0]       diff;

	assign trial = {rem_q, sh_q[W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			sh_q <= {sh_q[W-2:0], 1'b0};
			// The partial remainder always stays below a nonzero divisor.
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= trial[W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/rpl_parent_selection_top.sv =====
// Top level of the RPL parent selection and rank computation block.
// Neighbors arrive one beat each on the nbr channel and are written to a small table
// memory until MAX_NEIGHBORS are held; later neighbors are dropped but their last mark
// is still honored. The beat marked last_neighbor starts selection and the block stalls
// nbr until the run's parents have all been delivered. Selection makes one pass over the
// n stored neighbors per parent through the table's single read port, for min(n,
// PARENT_SET_SIZE) passes. The rank step then runs once per parent through a 16-step
// remainder divider that does the rank rounding. Each parent beat passes through the
// LOAD and SEND states and then waits out any stall on par.
// Configuration writes are always ready and are meant to arrive only while idle.
module rpl_parent_selection_top #(
	parameter int MAX_NEIGHBORS   = rps_pkg::MAX_NEIGHBORS_DEF,
	parameter int PARENT_SET_SIZE = rps_pkg::PARENT_SET_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rps_pkg::WORD_W-1:0]    cfg_data,
	input  logic                          nbr_valid,
	output logic                          nbr_stall,
	input  rps_pkg::nbr_t                 nbr,
	output logic                          par_valid,
	input  logic                          par_stall,
	output rps_pkg::par_t                 par
);

	localparam int W      = rps_pkg::WORD_W;
	localparam int PIDX_W = rps_pkg::PIDX_W;
	localparam int IDX_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
	localparam int SLOT_W = (PARENT_SET_SIZE > 1) ? $clog2(PARENT_SET_SIZE) : 1;
	localparam int NP_W   = $clog2(PARENT_SET_SIZE + 1);

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[W] ? rps_pkg::SAT_WORD : s[W-1:0];
	endfunction

	rps_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [W-1:0] min_hop_q;
	logic [W-1:0] max_inc_q;
	logic [W-1:0] unit;

	// Run bookkeeping.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_next;
	logic [CNT_W-1:0] n_q;
	logic [NP_W-1:0]  np_next;
	logic [NP_W-1:0]  np_q;
	logic [SLOT_W-1:0] slot_q;
	logic             last_slot;
	logic             nbr_acc;
	logic             store_we;
	rps_pkg::entry_t  wr_entry;

	// Selection scan.
	logic [CNT_W-1:0]         rd_q;
	logic                     mem_re;
	logic                     valid_s1;
	logic [IDX_W-1:0]         idx_s1;
	rps_pkg::entry_t          rdata;
	logic [W-1:0]             pc_s1;
	logic                     found_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [W-1:0]             best_pc_q;
	logic [W-1:0]             best_rank_q;
	logic [MAX_NEIGHBORS-1:0] taken_q;
	logic                     pass_done;
	logic                     better;

	// Selected parents in cost order.
	logic [IDX_W-1:0] par_idx_q  [PARENT_SET_SIZE];
	logic [W-1:0]     par_rank_q [PARENT_SET_SIZE];
	logic [W-1:0]     par_pc_q   [PARENT_SET_SIZE];

	// Rank computation.
	logic         div_start;
	logic         div_done;
	logic [W-1:0] div_rem;
	logic [W:0]   round_sum;
	logic [W-1:0] round_sat;
	logic [W-1:0] hop_rank;
	logic [W-1:0] path_rank;
	logic [W-1:0] a_q;
	logic [W-1:0] pr_q;
	logic [W-1:0] rank_q;
	logic [W-1:0] rank_base;
	logic [W-1:0] rank_t1;
	logic [W-1:0] pr_less;
	logic [W-1:0] rank_new;

	logic          par_valid_q;
	rps_pkg::par_t par_q;

	assign cfg_ready = 1'b1;
	assign unit      = (min_hop_q == '0) ? W'(1) : min_hop_q;

	assign nbr_acc  = nbr_valid && !nbr_stall;
	assign store_we = nbr_acc && (count_q < CNT_W'(MAX_NEIGHBORS));
	assign n_next   = store_we ? count_q + CNT_W'(1) : count_q;
	assign np_next  = (32'(n_next) < PARENT_SET_SIZE) ? NP_W'(n_next)
	                                                   : NP_W'(PARENT_SET_SIZE);
	assign last_slot = (32'(slot_q) + 1) == 32'(np_q);

	assign wr_entry.rank = nbr.neighbor_rank;
	assign wr_entry.cost = nbr.link_cost;

	rps_store #(
		.DEPTH (MAX_NEIGHBORS),
		.AW    (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (mem_re),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	rps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (par_rank_q[slot_q]),
		.divisor   (unit),
		.done      (div_done),
		.remainder (div_rem)
	);

	// A scan compares each read-back entry against the best untaken one so far; strict
	// less-than keeps the lower load index on equal costs.
	assign pc_s1     = sat_add(rdata.rank, rdata.cost);
	assign better    = valid_s1 && !taken_q[idx_s1] && (!found_q || (pc_s1 < best_pc_q));
	assign pass_done = (rd_q == n_q) && !valid_s1;

	// Rounding: unit * (1 + rank / unit) equals rank - (rank mod unit) + unit.
	assign round_sum = {1'b0, par_rank_q[slot_q]} - {1'b0, div_rem} + {1'b0, unit};
	assign round_sat = round_sum[W] ? rps_pkg::SAT_WORD : round_sum[W-1:0];
	assign hop_rank  = sat_add(par_rank_q[slot_q], min_hop_q);
	assign path_rank = (par_pc_q[slot_q] > hop_rank) ? par_pc_q[slot_q] : hop_rank;

	// The preferred parent's path rank seeds the node rank.
	assign rank_base = (slot_q == '0) ? pr_q : rank_q;
	assign rank_t1   = (a_q > rank_base) ? a_q : rank_base;
	assign pr_less   = pr_q - max_inc_q;
	assign rank_new  = ((pr_q > max_inc_q) && (pr_less > rank_t1)) ? pr_less : rank_t1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rps_pkg::ST_IDLE: begin
				if (nbr_acc && nbr.last_neighbor && (n_next != '0)) begin
					state_d = rps_pkg::ST_SEL;
				end
			end
			rps_pkg::ST_SEL: begin
				if (pass_done && last_slot) begin
					state_d = rps_pkg::ST_DIV_START;
				end
			end
			rps_pkg::ST_DIV_START: state_d = rps_pkg::ST_DIV_WAIT;
			rps_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = rps_pkg::ST_UPDATE;
				end
			end
			rps_pkg::ST_UPDATE: state_d = rps_pkg::ST_APPLY;
			rps_pkg::ST_APPLY: begin
				state_d = last_slot ? rps_pkg::ST_LOAD : rps_pkg::ST_DIV_START;
			end
			rps_pkg::ST_LOAD: state_d = rps_pkg::ST_SEND;
			rps_pkg::ST_SEND: begin
				if (!par_stall) begin
					state_d = last_slot ? rps_pkg::ST_IDLE : rps_pkg::ST_LOAD;
				end
			end
			default: state_d = rps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		nbr_stall = (state_q != rps_pkg::ST_IDLE);
		div_start = (state_q == rps_pkg::ST_DIV_START);
		mem_re    = (state_q == rps_pkg::ST_SEL) && (rd_q != n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rps_pkg::ST_IDLE;
			min_hop_q   <= rps_pkg::MIN_HOP_RESET;
			max_inc_q   <= rps_pkg::MAX_INC_RESET;
			count_q     <= '0;
			n_q         <= '0;
			np_q        <= '0;
			slot_q      <= '0;
			rd_q        <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			taken_q     <= '0;
			par_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rps_pkg::REG_MIN_HOP_RANK_INCREASE) begin
					min_hop_q <= cfg_data;
				end else if (cfg_index == rps_pkg::REG_MAX_RANK_INCREASE) begin
					max_inc_q <= cfg_data;
				end
			end
			unique case (state_q)
				rps_pkg::ST_IDLE: begin
					if (nbr_acc) begin
						if (nbr.last_neighbor) begin
							count_q  <= '0;
							n_q      <= n_next;
							np_q     <= np_next;
							slot_q   <= '0;
							rd_q     <= '0;
							valid_s1 <= 1'b0;
							found_q  <= 1'b0;
							taken_q  <= '0;
						end else begin
							count_q <= n_next;
						end
					end
				end
				rps_pkg::ST_SEL: begin
					if (rd_q != n_q) begin
						rd_q     <= rd_q + CNT_W'(1);
						valid_s1 <= 1'b1;
					end else begin
						valid_s1 <= 1'b0;
					end
					if (better) begin
						found_q <= 1'b1;
					end
					if (pass_done) begin
						found_q             <= 1'b0;
						rd_q                <= '0;
						taken_q[best_idx_q] <= 1'b1;
						slot_q              <= last_slot ? '0 : slot_q + SLOT_W'(1);
					end
				end
				rps_pkg::ST_APPLY: begin
					slot_q <= last_slot ? '0 : slot_q + SLOT_W'(1);
				end
				rps_pkg::ST_LOAD: begin
					par_valid_q <= 1'b1;
				end
				rps_pkg::ST_SEND: begin
					if (!par_stall) begin
						par_valid_q <= 1'b0;
						if (!last_slot) begin
							slot_q <= slot_q + SLOT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IDX_W-1:0];
		if (state_q == rps_pkg::ST_SEL) begin
			if (better) begin
				best_idx_q  <= idx_s1;
				best_pc_q   <= pc_s1;
				best_rank_q <= rdata.rank;
			end
			if (pass_done) begin
				par_idx_q[slot_q]  <= best_idx_q;
				par_rank_q[slot_q] <= best_rank_q;
				par_pc_q[slot_q]   <= best_pc_q;
			end
		end
		if (state_q == rps_pkg::ST_UPDATE) begin
			a_q  <= round_sat;
			pr_q <= path_rank;
		end
		if (state_q == rps_pkg::ST_APPLY) begin
			rank_q <= rank_new;
		end
		if (state_q == rps_pkg::ST_LOAD) begin
			par_q.parent_index     <= PIDX_W'(par_idx_q[slot_q]);
			par_q.parent_path_cost <= par_pc_q[slot_q];
			par_q.is_preferred     <= (slot_q == '0);
			par_q.own_rank         <= rank_q;
			par_q.last_parent      <= last_slot;
		end
	end

	assign par_valid = par_valid_q;
	assign par       = par_q;

	// No neighbor beat is taken while a parent beat is on offer.
	assert property (@(posedge clk) disable iff (!arst_n) par_valid |-> nbr_stall)
		else $error("neighbor accepted during parent delivery");

	// The final parent beat of a run is followed by an idle output.
	assert property (@(posedge clk) disable iff (!arst_n)
		par_valid && !par_stall && par.last_parent |=> !par_valid)
		else $error("parent beat after the last parent");

	// Within a run the next parent follows after the LOAD state, with the same rank.
	assert property (@(posedge clk) disable iff (!arst_n)
		par_valid && !par_stall && !par.last_parent |=> ##1
		(par_valid && !par.is_preferred && (par.own_rank == $past(par.own_rank, 2))))
		else $error("parent sequence broken within a run");

	// A run begins with the preferred parent.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(par_valid) && (state_q == rps_pkg::ST_SEND) && $past(nbr_stall, 1) &&
		($past(state_q, 2) == rps_pkg::ST_APPLY) |-> par.is_preferred)
		else $error("first parent of a run is not preferred");

endmodule
